// ===== hw/rtl/crv_pkg.sv =====
// crv_pkg: shared constants, datapath type and arctangent table for the cordic pipeline
// no dependencies; imported by crv_stage and cordic_rotate_vector
package crv_pkg;

    localparam int ITERATIONS    = 14;
    localparam int FRACTION_BITS = 16;
    localparam int TABLE_LEN     = 14;

    // micro-rotation stages actually built
    localparam int STAGES = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
    localparam int STEP_W = $clog2(TABLE_LEN);

    // table is held in q16.16 degrees, narrowed for smaller fraction widths
    localparam int ATAN_SHIFT = 16 - FRACTION_BITS;

    localparam int IN_W   = 16;
    localparam int DATA_W = 32;

    // atan(2^-i) in q16.16 degrees
    localparam logic [31:0] ATAN_Q16 [0:TABLE_LEN-1] = '{
        32'd2949120, 32'd1740967, 32'd919789, 32'd466945,
        32'd234379,  32'd117304,  32'd58666,  32'd29335,
        32'd14668,   32'd7334,    32'd3667,   32'd1833,
        32'd917,     32'd458
    };

    // one item in flight between stages
    typedef struct packed {
        logic                     vec;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } t_crv_data;

    // angle increment for one step, scaled to the fraction width
    function automatic logic signed [DATA_W-1:0] atan_step(input logic [STEP_W-1:0] s);
        logic signed [DATA_W-1:0] a;
        a = '0;
        if (32'(s) < TABLE_LEN) begin
            a = signed'(ATAN_Q16[s]) >>> ATAN_SHIFT;
        end
        return a;
    endfunction

endpackage

// ===== hw/rtl/crv_stage.sv =====
// crv_stage: one registered cordic micro-rotation with its own valid/ready slot
// depends on crv_pkg (t_crv_data, atan_step)
module crv_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [crv_pkg::STEP_W-1:0] i_step,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  crv_pkg::t_crv_data         i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output crv_pkg::t_crv_data         o_data
);
    import crv_pkg::*;

    logic                     r_valid;
    t_crv_data                r_data;
    t_crv_data                n_data;
    logic signed [DATA_W-1:0] xs;
    logic signed [DATA_W-1:0] ys;
    logic signed [DATA_W-1:0] a;
    logic                     neg;

    // slot frees when empty or when its item moves on
    assign o_ready = !r_valid || i_ready;

    // micro-rotation, direction from sign of y or z
    always_comb begin
        xs  = i_data.x >>> i_step;
        ys  = i_data.y >>> i_step;
        a   = atan_step(i_step);
        neg = i_data.vec ? !i_data.y[DATA_W-1] : i_data.z[DATA_W-1];
        n_data.vec = i_data.vec;
        if (neg) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + a;
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - a;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/cordic_rotate_vector.sv =====
// cordic_rotate_vector: pipelined circular cordic, rotation or vectoring mode
// pipeline: 15 register stages (entry + 14 rotations)
// throughput: one transaction per cycle unless i_m_axis_tready stalls; one item per stage
// reset: synchronous active-low i_rst_n empties every stage; payload is not cleared
// depends on crv_pkg and crv_stage
module cordic_rotate_vector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // x_in[15:0], y_in[31:16], z_in[47:32]
    input  logic [0:0]  i_s_axis_tuser,   // op[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata    // x_out[31:0], y_out[63:32], z_out[95:64]
);
    import crv_pkg::*;

    logic                     r_valid;
    t_crv_data                r_data;
    t_crv_data                n_data;
    logic signed [DATA_W-1:0] x_ext;
    logic signed [DATA_W-1:0] y_ext;
    logic signed [DATA_W-1:0] z_ext;

    logic      w_valid [0:STAGES];
    logic      w_ready [0:STAGES];
    t_crv_data w_data  [0:STAGES];

    // entry stage: sign extend and move into fixed point
    always_comb begin
        x_ext = {{(DATA_W-IN_W){i_s_axis_tdata[15]}}, i_s_axis_tdata[15:0]};
        y_ext = {{(DATA_W-IN_W){i_s_axis_tdata[31]}}, i_s_axis_tdata[31:16]};
        z_ext = {{(DATA_W-IN_W){i_s_axis_tdata[47]}}, i_s_axis_tdata[47:32]};
        n_data.vec = i_s_axis_tuser[0];
        n_data.x   = x_ext <<< FRACTION_BITS;
        n_data.y   = y_ext <<< FRACTION_BITS;
        n_data.z   = z_ext <<< FRACTION_BITS;
    end

    assign o_s_axis_tready = !r_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_data <= n_data;
        end
    end

    assign w_valid[0] = r_valid;
    assign w_data[0]  = r_data;

    // micro-rotation chain
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        crv_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_W'(k)),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    // last stage register drives the master side
    assign w_ready[STAGES] = i_m_axis_tready;
    assign o_m_axis_tvalid = w_valid[STAGES];
    assign o_m_axis_tdata  = {w_data[STAGES].z, w_data[STAGES].y, w_data[STAGES].x};

endmodule
